FILE: hdl/owik_pkg.sv
// shared types, constants and functions of the omni wheel inverse kinematics block
package owik_pkg;

    // command transaction, first field in the upper bits
    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] turn_rate;
        logic signed [15:0] heading;
        logic               world_frame;
    } owik_cmd_t;

    // result transaction
    typedef struct packed {
        logic signed [15:0] wheel0_rpm;
        logic signed [15:0] wheel1_rpm;
        logic signed [15:0] wheel2_rpm;
        logic signed [15:0] wheel3_rpm;
    } owik_result_t;

    // configuration register indexes
    localparam logic [1:0] REG_CHASSIS_RADIUS = 2'd0;
    localparam logic [1:0] REG_RPM_GAIN       = 2'd1;

    // reset values of the configuration registers
    localparam logic [11:0] RADIUS_RESET = 12'd300;
    localparam logic [31:0] GAIN_RESET   = 32'd65536;

    // pipeline depths
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned TRIG_LAT     = CORDIC_STEPS + 3;
    localparam int unsigned TURN_LAT     = 4;
    localparam int unsigned MIX_LAT      = 7;

    // heading handling in hundredths of a degree
    localparam logic signed [16:0] HALF_TURN    = 17'sd18000;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd9000;
    localparam logic signed [16:0] FULL_TURN    = 17'sd36000;

    // cordic datapath width and constants in q30
    localparam int unsigned       CORDIC_W     = 34;
    localparam logic signed [18:0] RAD_PER_CDEG = 19'sd187403;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    // wheel mixing
    localparam logic signed [15:0] COS45_Q15 = 16'sd23170;
    localparam int unsigned        TURN_W    = 49;

    // turn term: w*r*2^30/1000 = w*r*2^27/125, split as quotient and remainder by 125
    localparam longint unsigned TURN_DIV    = 125;
    localparam logic [28:0]     TURN_RECIP  = 29'd274877907;
    localparam int unsigned     RECIP_SHIFT = 35;
    localparam int unsigned     FRAC_DEPTH  = 128;

    // arctangent of 2^-i in q30
    function automatic logic [31:0] cordic_atan(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // fractional part of the turn term for remainder r, floor(r*2^27/125)
    function automatic logic [26:0] frac_entry(input int unsigned r);
        longint unsigned n;
        n = longint'(r) << 27;
        return 27'(n / TURN_DIV);
    endfunction

    // saturate to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7FFF;
        end
        else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/omni_wheel_inverse_kinematics_top.sv
// top level of the four omni wheel inverse kinematics pipeline
// throughput: one transaction per cycle, busy never asserts; depth is set by the
// 16-stage cordic plus rotation, mixing and the rpm gain multiply
// reset clears all valid bits and loads radius 300 mm and gain 1.0 (q16.16)
// done is high for exactly one cycle; the receiver must take the result then
module omni_wheel_inverse_kinematics_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  owik_pkg::owik_cmd_t     cmd,
    input  logic                    wr_en,
    input  logic [1:0]              wr_index,
    input  logic [31:0]             wr_data,
    output logic                    done,
    output owik_pkg::owik_result_t  result
);

    localparam int unsigned DLY = owik_pkg::TRIG_LAT;

    // configuration registers
    logic [11:0] radius_reg;
    logic [31:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radius_reg <= owik_pkg::RADIUS_RESET;
            gain_reg   <= owik_pkg::GAIN_RESET;
        end
        else if (wr_en) begin
            case (wr_index)
                owik_pkg::REG_CHASSIS_RADIUS: radius_reg <= wr_data[11:0];
                owik_pkg::REG_RPM_GAIN:       gain_reg   <= wr_data;
                default:                      ;
            endcase
        end
    end

    // the pipeline never stalls
    logic take;

    assign busy = 1'b0;
    assign take = start && !busy;

    // heading to cosine and sine
    logic               trig_vld;
    logic signed [15:0] cos_q15;
    logic signed [15:0] sin_q15;

    owik_trig u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (take),
        .heading (cmd.heading),
        .out_vld (trig_vld),
        .cos_q15 (cos_q15),
        .sin_q15 (sin_q15)
    );

    // command delay line aligned with the cordic output
    owik_pkg::owik_cmd_t cmd_dly_reg [DLY];

    always_ff @(posedge clk)
    begin
        cmd_dly_reg[0] <= cmd;
        for (int i = 1; i < DLY; i++) begin
            cmd_dly_reg[i] <= cmd_dly_reg[i-1];
        end
    end

    // turn term, lands at the mixer's fifth stage
    logic signed [owik_pkg::TURN_W-1:0] turn;

    owik_turn u_turn (
        .clk       (clk),
        .turn_rate (cmd_dly_reg[DLY-1].turn_rate),
        .radius    (radius_reg),
        .turn      (turn)
    );

    // rotation, mixing and scaling
    owik_mix u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (trig_vld),
        .cmd     (cmd_dly_reg[DLY-1]),
        .cos_q15 (cos_q15),
        .sin_q15 (sin_q15),
        .turn    (turn),
        .gain    (gain_reg),
        .out_vld (done),
        .result  (result)
    );

endmodule

FILE: hdl/owik_trig.sv
// pipelined cordic producing q1.15 cosine and sine of the heading
module owik_trig (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic signed [15:0] heading,
    output logic               out_vld,
    output logic signed [15:0] cos_q15,
    output logic signed [15:0] sin_q15
);

    localparam int unsigned W     = owik_pkg::CORDIC_W;
    localparam int unsigned STEPS = owik_pkg::CORDIC_STEPS;

    // wrap and fold stage
    logic signed [16:0] h_wrap;
    logic signed [14:0] h_fold;
    logic               fold_neg;
    logic signed [14:0] hf_reg;
    logic               pre_neg_reg;
    logic               pre_vld_reg;

    always_comb
    begin
        h_wrap = 17'(heading);
        if (h_wrap >= owik_pkg::HALF_TURN) begin
            h_wrap = h_wrap - owik_pkg::FULL_TURN;
        end
        else if (h_wrap < -owik_pkg::HALF_TURN) begin
            h_wrap = h_wrap + owik_pkg::FULL_TURN;
        end
        fold_neg = 1'b0;
        h_fold   = h_wrap[14:0];
        if (h_wrap > owik_pkg::QUARTER_TURN) begin
            h_fold   = 15'(h_wrap - owik_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end
        else if (h_wrap < -owik_pkg::QUARTER_TURN) begin
            h_fold   = 15'(h_wrap + owik_pkg::HALF_TURN);
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pre_vld_reg <= 1'b0;
        end
        else begin
            pre_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        hf_reg      <= h_fold;
        pre_neg_reg <= fold_neg;
    end

    // angle to q30 radians
    logic signed [W-1:0] z0_reg;
    logic                ang_neg_reg;
    logic                ang_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ang_vld_reg <= 1'b0;
        end
        else begin
            ang_vld_reg <= pre_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z0_reg      <= W'(hf_reg * owik_pkg::RAD_PER_CDEG);
        ang_neg_reg <= pre_neg_reg;
    end

    // one cordic iteration per stage
    logic signed [W-1:0] x_reg [STEPS];
    logic signed [W-1:0] y_reg [STEPS];
    logic signed [W-1:0] z_reg [STEPS];
    logic                neg_reg [STEPS];
    logic                vld_reg [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic signed [W-1:0] ATAN_G = $signed(W'(owik_pkg::cordic_atan(g)));
        logic signed [W-1:0] xi;
        logic signed [W-1:0] yi;
        logic signed [W-1:0] zi;
        logic                ni;
        logic                vi;

        if (g == 0) begin : g_first
            assign xi = owik_pkg::CORDIC_X0;
            assign yi = '0;
            assign zi = z0_reg;
            assign ni = ang_neg_reg;
            assign vi = ang_vld_reg;
        end
        else begin : g_next
            assign xi = x_reg[g-1];
            assign yi = y_reg[g-1];
            assign zi = z_reg[g-1];
            assign ni = neg_reg[g-1];
            assign vi = vld_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[g] <= 1'b0;
            end
            else begin
                vld_reg[g] <= vi;
            end
        end

        // rotate toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (!zi[W-1]) begin
                x_reg[g] <= xi - (yi >>> g);
                y_reg[g] <= yi + (xi >>> g);
                z_reg[g] <= zi - ATAN_G;
            end
            else begin
                x_reg[g] <= xi + (yi >>> g);
                y_reg[g] <= yi - (xi >>> g);
                z_reg[g] <= zi + ATAN_G;
            end
            neg_reg[g] <= ni;
        end
    end

    // unfold, round to q1.15 and clamp
    logic signed [W-1:0] x_fold;
    logic signed [W-1:0] y_fold;
    logic signed [W-1:0] x_round;
    logic signed [W-1:0] y_round;
    logic signed [15:0]  cos_reg;
    logic signed [15:0]  sin_reg;
    logic                out_vld_reg;

    always_comb
    begin
        x_fold  = neg_reg[STEPS-1] ? -x_reg[STEPS-1] : x_reg[STEPS-1];
        y_fold  = neg_reg[STEPS-1] ? -y_reg[STEPS-1] : y_reg[STEPS-1];
        x_round = (x_fold + 34'sd16384) >>> 15;
        y_round = (y_fold + 34'sd16384) >>> 15;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else begin
            out_vld_reg <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= owik_pkg::sat16(40'(x_round));
        sin_reg <= owik_pkg::sat16(40'(y_round));
    end

    assign out_vld = out_vld_reg;
    assign cos_q15 = cos_reg;
    assign sin_q15 = sin_reg;

endmodule

FILE: hdl/owik_turn.sv
// pipelined turn term w*r*2^30/1000 truncated toward zero
module owik_turn (
    input  logic                                 clk,
    input  logic signed [15:0]                   turn_rate,
    input  logic [11:0]                          radius,
    output logic signed [owik_pkg::TURN_W-1:0]   turn
);

    // remainder table, floor(r*2^27/125)
    logic [26:0] frac_tab [owik_pkg::FRAC_DEPTH];

    for (genvar g = 0; g < owik_pkg::FRAC_DEPTH; g++) begin : g_frac
        assign frac_tab[g] = owik_pkg::frac_entry(g);
    end

    // product of turn rate and radius
    logic signed [28:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 29'(turn_rate) * $signed({17'd0, radius});
    end

    // magnitude and quotient by 125 through the reciprocal
    logic [28:0] p_abs;
    logic [26:0] mag_x;
    logic [55:0] recip_prod;
    logic [26:0] x_reg;
    logic [20:0] q_reg;
    logic        sgn_reg;

    always_comb
    begin
        p_abs      = p_reg[28] ? 29'(-p_reg) : 29'(p_reg);
        mag_x      = p_abs[26:0];
        recip_prod = 56'(mag_x) * 56'(owik_pkg::TURN_RECIP);
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= mag_x;
        q_reg   <= recip_prod[owik_pkg::RECIP_SHIFT +: 21];
        sgn_reg <= p_reg[28];
    end

    // remainder by 125
    logic [27:0] q125;
    logic [27:0] rem_wide;
    logic [6:0]  r_reg;
    logic [20:0] q2_reg;
    logic        sgn2_reg;

    always_comb
    begin
        q125     = {q_reg, 7'd0} - {5'd0, q_reg, 2'd0} + {7'd0, q_reg};
        rem_wide = {1'b0, x_reg} - q125;
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= rem_wide[6:0];
        q2_reg   <= q_reg;
        sgn2_reg <= sgn_reg;
    end

    // assemble and restore the sign
    logic [47:0]                         mag;
    logic signed [owik_pkg::TURN_W-1:0]  mag_s;
    logic signed [owik_pkg::TURN_W-1:0]  turn_reg;

    always_comb
    begin
        mag   = {q2_reg, 27'd0} + {21'd0, frac_tab[r_reg]};
        mag_s = $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        turn_reg <= sgn2_reg ? -mag_s : mag_s;
    end

    assign turn = turn_reg;

endmodule

FILE: hdl/owik_mix.sv
// frame rotation, 45 degree wheel mixing, rpm scaling and saturation
module owik_mix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_vld,
    input  owik_pkg::owik_cmd_t                 cmd,
    input  logic signed [15:0]                  cos_q15,
    input  logic signed [15:0]                  sin_q15,
    // turn term, aligned with the cos 45 scaled mixing products
    input  logic signed [owik_pkg::TURN_W-1:0]  turn,
    input  logic [31:0]                         gain,
    output logic                                out_vld,
    output owik_pkg::owik_result_t              result
);

    localparam int unsigned LANES = 4;

    // valid bits travel with the stages
    logic [owik_pkg::MIX_LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= {vld_reg[owik_pkg::MIX_LAT-2:0], in_vld};
        end
    end

    // rotation products, robot frame uses cos = 1.0 and sin = 0
    logic signed [16:0] c17;
    logic signed [16:0] s17;
    logic signed [32:0] pxc_reg;
    logic signed [32:0] pys_reg;
    logic signed [32:0] pxs_reg;
    logic signed [32:0] pyc_reg;

    always_comb
    begin
        c17 = cmd.world_frame ? 17'(cos_q15) : 17'sd32768;
        s17 = cmd.world_frame ? 17'(sin_q15) : 17'sd0;
    end

    always_ff @(posedge clk)
    begin
        pxc_reg <= 33'(cmd.vel_x) * 33'(c17);
        pys_reg <= 33'(cmd.vel_y) * 33'(s17);
        pxs_reg <= 33'(cmd.vel_x) * 33'(s17);
        pyc_reg <= 33'(cmd.vel_y) * 33'(c17);
    end

    // robot frame velocities in q15
    logic signed [33:0] a_reg;
    logic signed [33:0] b_reg;

    always_ff @(posedge clk)
    begin
        a_reg <= 34'(pxc_reg) - 34'(pys_reg);
        b_reg <= 34'(pxs_reg) + 34'(pyc_reg);
    end

    // wheel mixing
    logic signed [34:0] m_reg [LANES];

    always_ff @(posedge clk)
    begin
        m_reg[0] <= 35'(a_reg) - 35'(b_reg);
        m_reg[1] <= -35'(a_reg) - 35'(b_reg);
        m_reg[2] <= 35'(b_reg) - 35'(a_reg);
        m_reg[3] <= 35'(a_reg) + 35'(b_reg);
    end

    // scale by cos 45 into q30
    logic signed [50:0] tm_reg [LANES];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++) begin
            tm_reg[i] <= 51'(m_reg[i]) * 51'(owik_pkg::COS45_Q15);
        end
    end

    // add turn term and round to q8
    logic signed [51:0] t_sum [LANES];
    logic signed [51:0] t_shift [LANES];
    logic signed [29:0] s8_reg [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++) begin
            t_sum[i]   = 52'(tm_reg[i]) + 52'(turn) + 52'sd2097152;
            t_shift[i] = t_sum[i] >>> 22;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++) begin
            s8_reg[i] <= t_shift[i][29:0];
        end
    end

    // rpm gain product
    logic signed [62:0] g_reg [LANES];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++) begin
            g_reg[i] <= 63'(s8_reg[i]) * 63'($signed({1'b0, gain}));
        end
    end

    // round, saturate and register the result
    logic signed [62:0]     g_round [LANES];
    logic signed [15:0]     rpm [LANES];
    owik_pkg::owik_result_t result_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++) begin
            g_round[i] = (g_reg[i] + 63'sd8388608) >>> 24;
            rpm[i]     = owik_pkg::sat16(g_round[i][39:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.wheel0_rpm <= rpm[0];
        result_reg.wheel1_rpm <= rpm[1];
        result_reg.wheel2_rpm <= rpm[2];
        result_reg.wheel3_rpm <= rpm[3];
    end

    assign out_vld = vld_reg[owik_pkg::MIX_LAT-1];
    assign result  = result_reg;

endmodule

FILE: test/tb_top.sv
// testbench for the four omni wheel inverse kinematics block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // run limits and pipeline settle time
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_WAIT  = 40;

    // register indexes past the end of the register list
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    // fixed point constants of the kinematics
    localparam longint HALF_TURN_CD    = 18000;
    localparam longint QUARTER_TURN_CD = 9000;
    localparam longint FULL_TURN_CD    = 36000;
    localparam longint CENTIDEG_TO_RAD = 187403;
    localparam longint CORDIC_START_X  = 652032874;
    localparam longint SQRT_HALF_Q15   = 23170;
    localparam int     ROTATION_STEPS  = 16;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    owik_pkg::owik_cmd_t        cmd = '0;
    logic                       wr_en = 1'b0;
    logic [1:0]                 wr_index = '0;
    logic [31:0]                wr_data = '0;
    logic                       done;
    owik_pkg::owik_result_t     result;

    // shadow copy of the configuration registers
    logic [11:0]    radius_mm_cfg = 12'd300;
    logic [31:0]    rpm_gain_cfg = 32'd65536;

    owik_pkg::owik_result_t expected_speeds[$];
    int unsigned    mismatch_count = 0;
    int unsigned    results_checked = 0;
    int unsigned    cycle_count = 0;
    bit             no_idle = 1'b0;

    omni_wheel_inverse_kinematics_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .done     (done),
        .result   (result)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // arctangent of 2^-k in q30
    function automatic longint arctan_q30(input int k);
        longint v;
        case (k)
            0:       v = 64'h3243F6A8;
            1:       v = 64'h1DAC6705;
            2:       v = 64'h0FADBAFC;
            3:       v = 64'h07F56EA6;
            4:       v = 64'h03FEAB76;
            5:       v = 64'h01FFD55B;
            6:       v = 64'h00FFFAAA;
            7:       v = 64'h007FFF55;
            8:       v = 64'h003FFFEA;
            9:       v = 64'h001FFFFD;
            10:      v = 64'h000FFFFF;
            11:      v = 64'h0007FFFF;
            12:      v = 64'h0003FFFF;
            13:      v = 64'h0001FFFF;
            14:      v = 64'h0000FFFF;
            default: v = 64'h00007FFF;
        endcase
        return v;
    endfunction

    function automatic longint clamp16(input longint v);
        longint r;
        if (v > 32767)
        begin
            r = 32767;
        end
        else if (v < -32768)
        begin
            r = -32768;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // cosine and sine of the heading in q1.15, rotation by shifts and adds
    function automatic void heading_cos_sin(input logic signed [15:0] hd,
                                            output longint cos_q15,
                                            output longint sin_q15);
        longint h;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        h = hd;
        flip = 1'b0;
        x = CORDIC_START_X;
        y = 0;
        // wrap into one turn, then fold into the right half plane
        if (h >= HALF_TURN_CD) h -= FULL_TURN_CD;
        if (h < -HALF_TURN_CD) h += FULL_TURN_CD;
        if (h > QUARTER_TURN_CD)
        begin
            h -= HALF_TURN_CD;
            flip = 1'b1;
        end
        else if (h < -QUARTER_TURN_CD)
        begin
            h += HALF_TURN_CD;
            flip = 1'b1;
        end
        z = h * CENTIDEG_TO_RAD;
        for (int k = 0; k < ROTATION_STEPS; k++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> k);
                y = y + (x >>> k);
                z -= arctan_q30(k);
            end
            else
            begin
                nx = x + (y >>> k);
                y = y - (x >>> k);
                z += arctan_q30(k);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q15 = clamp16((x + 16384) >>> 15);
        sin_q15 = clamp16((y + 16384) >>> 15);
    endfunction

    // one wheel: q30 sum rounded to q8, times the q16.16 gain, saturated
    function automatic logic signed [15:0] wheel_rpm_of(input longint mix_q15,
                                                        input longint turn_q30);
        longint t;
        longint s8;
        longint g;
        longint r;
        g = rpm_gain_cfg;
        t = mix_q15 * SQRT_HALF_Q15 + turn_q30;
        s8 = (t + (64'sd1 <<< 21)) >>> 22;
        r = (s8 * g + (64'sd1 <<< 23)) >>> 24;
        return 16'(clamp16(r));
    endfunction

    // four wheel speeds for one motion command
    function automatic owik_pkg::owik_result_t wheel_speeds_for(input owik_pkg::owik_cmd_t c);
        owik_pkg::owik_result_t o;
        longint vx;
        longint vy;
        longint w;
        longint rad;
        longint cs;
        longint sn;
        longint a;
        longint b;
        longint turn;
        vx = c.vel_x;
        vy = c.vel_y;
        w = c.turn_rate;
        rad = radius_mm_cfg;
        if (c.world_frame)
        begin
            heading_cos_sin(c.heading, cs, sn);
            a = vx * cs - vy * sn;
            b = vx * sn + vy * cs;
        end
        else
        begin
            a = vx * 32768;
            b = vy * 32768;
        end
        turn = (w * rad * (64'sd1 <<< 30)) / 1000;
        o.wheel0_rpm = wheel_rpm_of(a - b, turn);
        o.wheel1_rpm = wheel_rpm_of(-a - b, turn);
        o.wheel2_rpm = wheel_rpm_of(b - a, turn);
        o.wheel3_rpm = wheel_rpm_of(a + b, turn);
        return o;
    endfunction

    function automatic owik_pkg::owik_cmd_t make_cmd(input int vx, input int vy, input int w,
                                                     input int h, input bit wf);
        owik_pkg::owik_cmd_t c;
        c.vel_x = 16'(vx);
        c.vel_y = 16'(vy);
        c.turn_rate = 16'(w);
        c.heading = 16'(h);
        c.world_frame = wf;
        return c;
    endfunction

    // speed values: full range, near zero or at the rails
    function automatic int random_speed();
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 4000)) - 2000;
            1:       v = $urandom_range(0, 1) ? 32767 : -32768;
            default: v = int'($signed(16'($urandom)));
        endcase
        return v;
    endfunction

    function automatic owik_pkg::owik_cmd_t random_command();
        int h;
        if ($urandom_range(0, 3) == 0)
        begin
            h = int'($signed(16'($urandom)));
        end
        else
        begin
            h = int'($urandom_range(0, 36000)) - 18000;
        end
        return make_cmd(random_speed(), random_speed(), random_speed(), h,
                        1'($urandom_range(0, 1)));
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb_top: mismatch at result %0d: %s", results_checked, what);
        mismatch_count++;
    endtask

    // register write, one cycle of write enable
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == owik_pkg::REG_CHASSIS_RADIUS)
        begin
            radius_mm_cfg = data[11:0];
        end
        else if (idx == owik_pkg::REG_RPM_GAIN)
        begin
            rpm_gain_cfg = data;
        end
        @(posedge clk);
    endtask

    // send one command transaction after a random gap, or none while no_idle is set; start stays high afterwards
    task automatic send_command(input owik_pkg::owik_cmd_t c);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        expected_speeds.push_back(wheel_speeds_for(c));
    endtask

    // hold off until every expected result has arrived and the pipeline is empty
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_speeds.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // reset register values, field extremes and heading wrap and fold points
    task automatic test_directed_commands();
        send_command(make_cmd(0, 0, 0, 0, 1'b0));
        send_command(make_cmd(32767, 0, 0, 0, 1'b0));
        send_command(make_cmd(-32768, 0, 0, 0, 1'b0));
        send_command(make_cmd(0, 32767, 0, 0, 1'b0));
        send_command(make_cmd(0, -32768, 0, 0, 1'b0));
        send_command(make_cmd(0, 0, 32767, 0, 1'b0));
        send_command(make_cmd(0, 0, -32768, 0, 1'b0));
        // wheel speed past 16 bits saturates both ways
        send_command(make_cmd(32767, -32768, 32767, 0, 1'b0));
        send_command(make_cmd(-32768, 32767, -32768, 0, 1'b0));
        // headings at the fold and wrap boundaries
        send_command(make_cmd(1000, 500, 100, 9000, 1'b1));
        send_command(make_cmd(1000, 500, 100, 9001, 1'b1));
        send_command(make_cmd(1000, 500, 100, -9000, 1'b1));
        send_command(make_cmd(1000, 500, 100, -9001, 1'b1));
        send_command(make_cmd(1000, 500, 100, 18000, 1'b1));
        send_command(make_cmd(1000, 500, 100, -18000, 1'b1));
        send_command(make_cmd(-700, 1200, -50, 32767, 1'b1));
        send_command(make_cmd(-700, 1200, -50, -32768, 1'b1));
        wait_for_results();
    endtask

    // register extremes, masked radius bits and writes past the register list
    task automatic test_register_extremes();
        write_reg(owik_pkg::REG_CHASSIS_RADIUS, 32'd0);
        write_reg(owik_pkg::REG_RPM_GAIN, 32'd0);
        send_command(make_cmd(32767, -32768, 32767, 4500, 1'b1));
        send_command(make_cmd(1234, -321, -32768, 0, 1'b0));
        wait_for_results();
        write_reg(owik_pkg::REG_CHASSIS_RADIUS, 32'd4095);
        write_reg(owik_pkg::REG_RPM_GAIN, 32'hFFFF_FFFF);
        send_command(make_cmd(1, 0, 0, 0, 1'b0));
        send_command(make_cmd(0, 0, 32767, 0, 1'b0));
        send_command(make_cmd(0, 0, -1, 0, 1'b0));
        wait_for_results();
        write_reg(owik_pkg::REG_CHASSIS_RADIUS, 32'hFFFF_F001);
        write_reg(owik_pkg::REG_RPM_GAIN, 32'd65536);
        write_reg(REG_SPARE_2, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_3, 32'h5555_AAAA);
        send_command(make_cmd(300, 200, 20000, -4500, 1'b1));
        send_command(make_cmd(-300, 200, -20000, 0, 1'b0));
        wait_for_results();
    endtask

    // random commands in phases with fresh register values between them
    task automatic test_random_commands();
        logic [31:0] gain;
        for (int phase = 0; phase < 4; phase++)
        begin
            gain = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0003_0000);
            write_reg(owik_pkg::REG_CHASSIS_RADIUS, $urandom);
            write_reg(owik_pkg::REG_RPM_GAIN, gain);
            if ($urandom_range(0, 1))
            begin
                write_reg(2'($urandom_range(REG_SPARE_2, REG_SPARE_3)), $urandom);
            end
            for (int n = 0; n < 100; n++)
            begin
                // bursts with no gaps between stretches of random gaps
                no_idle = ((n / 20) % 3 == 2);
                if (n == 50 && phase == 1)
                begin
                    wait_for_results();
                end
                send_command(random_command());
            end
            no_idle = 1'b0;
            wait_for_results();
        end
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_speeds
        owik_pkg::owik_result_t want;
        if (rst_n && done)
        begin
            if (expected_speeds.size() == 0)
            begin
                report_mismatch("result with no command pending");
            end
            else
            begin
                want = expected_speeds.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (result[63 - 16 * i -: 16] !== want[63 - 16 * i -: 16])
                    begin
                        report_mismatch($sformatf("wheel%0d rpm got %0d want %0d", i,
                                        $signed(result[63 - 16 * i -: 16]),
                                        $signed(want[63 - 16 * i -: 16])));
                    end
                end
            end
            results_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed_commands();
        test_register_extremes();
        test_random_commands();
        wait_for_results();
        if (mismatch_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
